@@ src/pbrd_pkg.sv @@
package pbrd_pkg;

   // Largest row width and row count that the block supports.
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_ROWS  = 1024;

   // Field and register widths.
   localparam int BYTE_W = 8;
   localparam int CFG_W  = 11;
   localparam int IDX_W  = 2;

   // Counter widths that follow from the limits.
   localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int TOT_W   = $clog2(MAX_ROWS + 1);
   localparam int WEXT_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
   localparam int REXT_W  = (CFG_W > TOT_W) ? CFG_W : TOT_W;
   localparam int SUM_W   = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
   localparam logic [IDX_W-1:0] REG_ROW_TOTAL = 2'd1;

   // Reset values of the registers.
   localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd320;
   localparam logic [CFG_W-1:0] ROW_TOTAL_RESET = 11'd200;

   // Header codes.
   localparam logic [BYTE_W-1:0] HDR_NOP = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;
   localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd2;

   // Decoder phases.
   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_REPEAT  = 2'd1;
   localparam logic [1:0] PHASE_LITERAL = 2'd2;

endpackage

@@ src/packbits_row_decoder.sv @@
// PackBits row decoder. One compressed byte is taken per cycle and, when it
// completes a piece of output, the piece appears in the next cycle in the result
// register as a pixel value with a run length (1 for literal bytes), together
// with row and image end flags. Header bytes, including the no-op header 0x80,
// are consumed without a result. The sustained rate is one byte per cycle,
// set by the single decode stage in front of the result register; the input
// is only stalled while a held result is itself stalled. A row ends after the
// packet that brings the pixel count to row_width or beyond (runs are not
// clipped), and image_end marks the row that completes row_total rows.
// Register writes take effect on the next byte; a zero register acts as 1 and
// values above the supported limits are clamped.
module packbits_row_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pbrd_pkg::BYTE_W-1:0]   req_coded_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pbrd_pkg::BYTE_W-1:0]   rsp_pixel_value,
   output logic [pbrd_pkg::BYTE_W-1:0]   rsp_run_length,
   output logic                          rsp_row_end,
   output logic                          rsp_image_end,
   input  logic                          csr_write,
   input  logic [pbrd_pkg::IDX_W-1:0]    csr_index,
   input  logic [pbrd_pkg::CFG_W-1:0]    csr_wdata
);
   import pbrd_pkg::*;

   logic [CFG_W-1:0]  row_width_ff;
   logic [CFG_W-1:0]  row_total_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] literal_left_ff, literal_left_in;
   logic [BYTE_W-1:0] pending_run_ff, pending_run_in;
   logic [CNT_W-1:0]  pixel_count_ff, pixel_count_in;
   logic [ROW_W-1:0]  rows_done_ff, rows_done_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_value_ff, out_value_in;
   logic [BYTE_W-1:0] out_run_ff, out_run_in;
   logic              out_row_end_ff, out_row_end_in;
   logic              out_image_end_ff, out_image_end_in;

   logic              accept;
   logic              advance;
   logic [WEXT_W-1:0] width_ext;
   logic [REXT_W-1:0] total_ext;
   logic [CNT_W-1:0]  eff_width;
   logic [TOT_W-1:0]  eff_total;
   logic [BYTE_W-1:0] add_amount;
   logic [SUM_W-1:0]  pixel_sum;
   logic [CNT_W-1:0]  pixel_sat;
   logic [TOT_W-1:0]  rows_next;
   logic              packet_done;
   logic              row_done;
   logic              last_row;
   logic [BYTE_W-1:0] literal_dec;

   // The result register advances when it is empty or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Effective register values: zero acts as one, large values clamp.
   assign width_ext = WEXT_W'(row_width_ff);
   assign total_ext = REXT_W'(row_total_ff);

   always_comb begin
      priority if (row_width_ff == '0) begin
         eff_width = CNT_W'(1);
      end else if (width_ext > WEXT_W'(MAX_WIDTH)) begin
         eff_width = CNT_W'(MAX_WIDTH);
      end else begin
         eff_width = CNT_W'(width_ext);
      end
      priority if (row_total_ff == '0) begin
         eff_total = TOT_W'(1);
      end else if (total_ext > REXT_W'(MAX_ROWS)) begin
         eff_total = TOT_W'(MAX_ROWS);
      end else begin
         eff_total = TOT_W'(total_ext);
      end
   end

   // Pixel count after this item, saturating at the largest width.
   assign add_amount = (phase_ff == PHASE_REPEAT) ? pending_run_ff : BYTE_W'(1);
   assign pixel_sum  = SUM_W'(pixel_count_ff) + SUM_W'(add_amount);
   assign pixel_sat  = (pixel_sum > SUM_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH)
                                                        : CNT_W'(pixel_sum);
   assign literal_dec = (literal_left_ff != '0) ? literal_left_ff - BYTE_W'(1)
                                                : literal_left_ff;

   // Row and image checks at the end of a packet.
   assign packet_done = (phase_ff == PHASE_REPEAT) ||
                        ((phase_ff == PHASE_LITERAL) && (literal_dec == '0));
   assign row_done    = packet_done && (pixel_sat >= eff_width);
   assign rows_next   = TOT_W'(rows_done_ff) + TOT_W'(1);
   assign last_row    = rows_next >= eff_total;

   // Decode step for one accepted item.
   always_comb begin
      phase_in         = phase_ff;
      literal_left_in  = literal_left_ff;
      pending_run_in   = pending_run_ff;
      pixel_count_in   = pixel_count_ff;
      rows_done_in     = rows_done_ff;
      out_valid_in     = out_valid_ff && rsp_stall;
      out_value_in     = out_value_ff;
      out_run_in       = out_run_ff;
      out_row_end_in   = out_row_end_ff;
      out_image_end_in = out_image_end_ff;
      if (accept) begin
         unique case (phase_ff)
            PHASE_REPEAT, PHASE_LITERAL: begin
               out_valid_in     = 1'b1;
               out_value_in     = req_coded_byte;
               out_run_in       = add_amount;
               out_row_end_in   = row_done;
               out_image_end_in = row_done && last_row;
               pending_run_in   = (phase_ff == PHASE_REPEAT) ? '0 : pending_run_ff;
               literal_left_in  = (phase_ff == PHASE_LITERAL) ? literal_dec
                                                               : literal_left_ff;
               phase_in         = packet_done ? PHASE_HEADER : phase_ff;
               pixel_count_in   = row_done ? '0 : pixel_sat;
               if (row_done) begin
                  rows_done_in = last_row ? '0 : ROW_W'(rows_next);
               end
            end
            default: begin
               // Header byte: set up the packet, no result.
               if (req_coded_byte > HDR_NOP) begin
                  pending_run_in = (req_coded_byte ^ BYTE_ONES) + RUN_BIAS;
                  phase_in       = PHASE_REPEAT;
               end else if (req_coded_byte < HDR_NOP) begin
                  literal_left_in = req_coded_byte + BYTE_W'(1);
                  phase_in        = PHASE_LITERAL;
               end
            end
         endcase
      end
   end

   // Control state and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff    <= ROW_WIDTH_RESET;
         row_total_ff    <= ROW_TOTAL_RESET;
         phase_ff        <= PHASE_HEADER;
         literal_left_ff <= '0;
         pending_run_ff  <= '0;
         pixel_count_ff  <= '0;
         rows_done_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         literal_left_ff <= literal_left_in;
         pending_run_ff  <= pending_run_in;
         pixel_count_ff  <= pixel_count_in;
         rows_done_ff    <= rows_done_in;
         out_valid_ff    <= out_valid_in;
         if (csr_write && (csr_index == REG_ROW_WIDTH)) begin
            row_width_ff <= csr_wdata;
         end
         if (csr_write && (csr_index == REG_ROW_TOTAL)) begin
            row_total_ff <= csr_wdata;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      out_value_ff     <= out_value_in;
      out_run_ff       <= out_run_in;
      out_row_end_ff   <= out_row_end_in;
      out_image_end_ff <= out_image_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_value = out_value_ff;
   assign rsp_run_length  = out_run_ff;
   assign rsp_row_end     = out_row_end_ff;
   assign rsp_image_end   = out_image_end_ff;

endmodule
